// ----- sv/asfp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the arm status frame parser.
// No dependencies; used by the result stage, the top level and the testbench.
package asfp_pkg;

    // Frame geometry: begin marker, six value bytes, kind byte, end marker.
    localparam int FRAME_LEN  = 9;
    localparam int STORE_LEN  = FRAME_LEN - 1;
    localparam int IDX_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int VALUE_W    = 17;
    localparam int KIND_W     = 2;

    // Frame byte positions.
    localparam int POS_X    = 1;
    localparam int POS_Y    = 3;
    localparam int POS_Z    = 5;
    localparam int POS_KIND = 7;

    // Largest kind code that produces a result.
    localparam logic [7:0] KIND_MAX      = 8'd3;
    localparam logic [7:0] KIND_POSITION = 8'd0;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BYTE_ORDER   = 3'd0,
        CFG_BEGIN_MARKER = 3'd1,
        CFG_END_MARKER   = 3'd2,
        CFG_ORIGIN_X     = 3'd3,
        CFG_ORIGIN_Y     = 3'd4,
        CFG_ORIGIN_Z     = 3'd5
    } t_cfg_idx;

    // Configuration register set handed to the result stage.
    typedef struct packed {
        logic               byte_order;
        logic [7:0]         begin_marker;
        logic [7:0]         end_marker;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic signed [15:0] origin_z;
    } t_cfg;

    // Frame bytes 0 to 7, index j holds frame byte j.
    typedef logic [STORE_LEN-1:0][7:0] t_frame;

endpackage

// ----- sv/asfp_cell.sv -----
`timescale 1ns / 1ps
// One byte cell of the frame shift chain.
// Depends on nothing; instantiated in a row by the top level.
module asfp_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    output logic [7:0] o_byte
);

    logic [7:0] r_byte;

    // Take the neighbor's byte whenever the chain advances.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// ----- sv/asfp_result.sv -----
`timescale 1ns / 1ps
// Result stage: end marker and kind check, value unpacking, origin offset,
// and the output register. Depends on asfp_pkg.
module asfp_result (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_last,
    input  logic [7:0]                           i_rx_byte,
    input  asfp_pkg::t_frame                     i_frame,
    input  asfp_pkg::t_cfg                       i_cfg,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic [asfp_pkg::KIND_W-1:0]          o_frame_kind,
    output logic signed [asfp_pkg::VALUE_W-1:0]  o_value_x,
    output logic signed [asfp_pkg::VALUE_W-1:0]  o_value_y,
    output logic signed [asfp_pkg::VALUE_W-1:0]  o_value_z
);

    logic                                r_valid;
    logic [asfp_pkg::KIND_W-1:0]         r_kind;
    logic signed [asfp_pkg::VALUE_W-1:0] r_x;
    logic signed [asfp_pkg::VALUE_W-1:0] r_y;
    logic signed [asfp_pkg::VALUE_W-1:0] r_z;

    logic                                w_load;
    logic                                w_pos;
    logic [7:0]                          w_kind;
    logic signed [asfp_pkg::VALUE_W-1:0] w_x;
    logic signed [asfp_pkg::VALUE_W-1:0] w_y;
    logic signed [asfp_pkg::VALUE_W-1:0] w_z;

    // Join two bytes in the configured order and widen with sign.
    function automatic logic signed [asfp_pkg::VALUE_W-1:0] unpack(
        input logic [7:0] a,
        input logic [7:0] b,
        input logic       msb_first
    );
        logic [15:0] w;
        begin
            w = msb_first ? {a, b} : {b, a};
            return {w[15], w};
        end
    endfunction

    // Sign-extend an origin register to the value width.
    function automatic logic signed [asfp_pkg::VALUE_W-1:0] widen(
        input logic signed [15:0] v
    );
        return {v[15], v};
    endfunction

    // Decide whether the closing byte completes a good frame.
    assign w_kind = i_frame[asfp_pkg::POS_KIND];
    assign w_load = i_last && (i_rx_byte == i_cfg.end_marker)
                    && (w_kind <= asfp_pkg::KIND_MAX);
    assign w_pos  = (w_kind == asfp_pkg::KIND_POSITION);

    // Unpack the three values; position frames are taken relative to origin.
    always_comb begin
        w_x = unpack(i_frame[asfp_pkg::POS_X], i_frame[asfp_pkg::POS_X + 1],
                     i_cfg.byte_order);
        w_y = unpack(i_frame[asfp_pkg::POS_Y], i_frame[asfp_pkg::POS_Y + 1],
                     i_cfg.byte_order);
        w_z = unpack(i_frame[asfp_pkg::POS_Z], i_frame[asfp_pkg::POS_Z + 1],
                     i_cfg.byte_order);
        if (w_pos) begin
            w_x = w_x - widen(i_cfg.origin_x);
            w_y = w_y - widen(i_cfg.origin_y);
            w_z = w_z - widen(i_cfg.origin_z);
        end
    end

    // Output register: a new word loads only when the previous one is gone.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind <= w_kind[asfp_pkg::KIND_W-1:0];
            r_x    <= w_x;
            r_y    <= w_y;
            r_z    <= w_z;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_frame_kind = r_kind;
    assign o_value_x    = r_x;
    assign o_value_y    = r_y;
    assign o_value_z    = r_z;

endmodule

// ----- sv/arm_status_frame_parser_unit.sv -----
`timescale 1ns / 1ps
// Arm status frame parser: one received byte per accepted word; a good frame
// yields one result word in the cycle after its end marker byte is accepted.
// Throughput is one byte every cycle while o_in_stall is low; the byte chain
// shifts once per stored byte, the result register loads as the last drains.
// Synchronous active-low reset clears the byte counter (hunting for the begin
// marker), the output valid and the configuration registers to their defaults.
module arm_status_frame_parser_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [asfp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [asfp_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [7:0]                             i_rx_byte,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [asfp_pkg::KIND_W-1:0]            o_frame_kind,
    output logic signed [asfp_pkg::VALUE_W-1:0]    o_value_x,
    output logic signed [asfp_pkg::VALUE_W-1:0]    o_value_y,
    output logic signed [asfp_pkg::VALUE_W-1:0]    o_value_z
);

    asfp_pkg::t_cfg                    r_cfg;
    logic [asfp_pkg::IDX_W-1:0]        r_byte_idx;
    logic [asfp_pkg::IDX_W-1:0]        n_byte_idx;

    logic                              w_accept;
    logic                              w_hunting;
    logic                              w_shift;
    logic                              w_last;
    logic [7:0]                        w_cell [asfp_pkg::STORE_LEN];
    asfp_pkg::t_frame                  w_frame;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.byte_order   <= 1'b1;
            r_cfg.begin_marker <= 8'h00;
            r_cfg.end_marker   <= 8'hFF;
            r_cfg.origin_x     <= '0;
            r_cfg.origin_y     <= '0;
            r_cfg.origin_z     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                asfp_pkg::CFG_BYTE_ORDER:   r_cfg.byte_order   <= i_cfg_data[0];
                asfp_pkg::CFG_BEGIN_MARKER: r_cfg.begin_marker <= i_cfg_data[7:0];
                asfp_pkg::CFG_END_MARKER:   r_cfg.end_marker   <= i_cfg_data[7:0];
                asfp_pkg::CFG_ORIGIN_X:     r_cfg.origin_x     <= i_cfg_data;
                asfp_pkg::CFG_ORIGIN_Y:     r_cfg.origin_y     <= i_cfg_data;
                asfp_pkg::CFG_ORIGIN_Z:     r_cfg.origin_z     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input handshake: hold off only while a finished word waits downstream.
    assign o_in_stall = o_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Frame tracking: a count of zero (or out of range) means hunting.
    assign w_hunting = (r_byte_idx == '0)
                       || (r_byte_idx >= asfp_pkg::IDX_W'(asfp_pkg::FRAME_LEN));
    assign w_last    = w_accept && !w_hunting
                       && (r_byte_idx == asfp_pkg::IDX_W'(asfp_pkg::STORE_LEN));
    assign w_shift   = w_accept && (w_hunting ? (i_rx_byte == r_cfg.begin_marker)
                                              : !w_last);

    always_comb begin
        n_byte_idx = r_byte_idx;
        if (w_accept) begin
            if (w_hunting) begin
                n_byte_idx = (i_rx_byte == r_cfg.begin_marker) ? 4'd1 : 4'd0;
            end else if (w_last) begin
                n_byte_idx = '0;
            end else begin
                n_byte_idx = r_byte_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_idx <= '0;
        end else begin
            r_byte_idx <= n_byte_idx;
        end
    end

    // Row of byte cells: new bytes enter cell 0 and move one cell per shift,
    // so after the eight stored bytes frame byte j sits in cell 7 - j.
    genvar k;
    generate
        for (k = 0; k < asfp_pkg::STORE_LEN; k++) begin : g_cell
            asfp_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_byte ((k == 0) ? i_rx_byte : w_cell[(k == 0) ? 0 : k - 1]),
                .o_byte (w_cell[k])
            );
            assign w_frame[asfp_pkg::STORE_LEN - 1 - k] = w_cell[k];
        end
    endgenerate

    // Result stage with output register.
    asfp_result u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_last      (w_last),
        .i_rx_byte   (i_rx_byte),
        .i_frame     (w_frame),
        .i_cfg       (r_cfg),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_frame_kind(o_frame_kind),
        .o_value_x   (o_value_x),
        .o_value_y   (o_value_y),
        .o_value_z   (o_value_z)
    );

    // The byte counter never leaves the frame range.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_idx <= asfp_pkg::IDX_W'(asfp_pkg::STORE_LEN))
        else $error("byte counter out of range");

    // A new result word follows only the acceptance of a closing byte.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_last))
        else $error("result word without a closing byte");

    // A non-marker byte seen while hunting keeps the parser hunting.
    a_hunt_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_byte_idx == '0 && i_rx_byte != r_cfg.begin_marker)
        |=> (r_byte_idx == '0))
        else $error("left hunting without a begin marker");

endmodule

// ----- verif/arm_status_frame_parser_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the arm status frame parser unit.
// Depends on asfp_pkg and arm_status_frame_parser_unit; predicts every status
// word from the received byte stream and compares it field by field.
module arm_status_frame_parser_unit_tb;

    // One decoded status word as the block should report it.
    typedef struct {
        logic [asfp_pkg::KIND_W-1:0]         kind;
        logic signed [asfp_pkg::VALUE_W-1:0] x;
        logic signed [asfp_pkg::VALUE_W-1:0] y;
        logic signed [asfp_pkg::VALUE_W-1:0] z;
    } t_frame_status;

    // Tracks the parser state and configuration and holds the status words
    // still owed by the block, oldest first.
    class t_status_board;
        logic               byte_order;
        logic [7:0]         begin_marker;
        logic [7:0]         end_marker;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic signed [15:0] origin_z;
        logic [7:0]         frame_bytes [asfp_pkg::STORE_LEN];
        int unsigned        bytes_held;
        t_frame_status      pending_status [$];
        int unsigned        errors;

        function new();
            byte_order   = 1'b1;
            begin_marker = 8'h00;
            end_marker   = 8'hFF;
            origin_x     = '0;
            origin_y     = '0;
            origin_z     = '0;
            bytes_held   = 0;
            errors       = 0;
        endfunction

        function void set_reg(asfp_pkg::t_cfg_idx idx,
                              logic [asfp_pkg::CFG_DATA_W-1:0] d);
            case (idx)
                asfp_pkg::CFG_BYTE_ORDER:   byte_order   = d[0];
                asfp_pkg::CFG_BEGIN_MARKER: begin_marker = d[7:0];
                asfp_pkg::CFG_END_MARKER:   end_marker   = d[7:0];
                asfp_pkg::CFG_ORIGIN_X:     origin_x     = d;
                asfp_pkg::CFG_ORIGIN_Y:     origin_y     = d;
                asfp_pkg::CFG_ORIGIN_Z:     origin_z     = d;
                default: ;
            endcase
        endfunction

        // Joins two frame bytes in the configured order, sign extended.
        function logic signed [asfp_pkg::VALUE_W-1:0] pair_value(int pos);
            logic [15:0] w;
            w = byte_order ? {frame_bytes[pos], frame_bytes[pos+1]}
                           : {frame_bytes[pos+1], frame_bytes[pos]};
            return {w[15], w};
        endfunction

        // Advances the parser by one accepted byte and queues any status word.
        function void take_rx_byte(logic [7:0] b);
            t_frame_status s;
            if (bytes_held == 0 || bytes_held >= asfp_pkg::FRAME_LEN) begin
                bytes_held = 0;
                if (b == begin_marker) begin
                    frame_bytes[0] = b;
                    bytes_held = 1;
                end
                return;
            end
            if (bytes_held < asfp_pkg::STORE_LEN) begin
                frame_bytes[bytes_held] = b;
                bytes_held++;
                return;
            end
            // Last byte: drop the frame on a bad end marker or unknown kind.
            bytes_held = 0;
            if (b != end_marker || frame_bytes[asfp_pkg::POS_KIND] > asfp_pkg::KIND_MAX)
                return;
            s.kind = frame_bytes[asfp_pkg::POS_KIND][asfp_pkg::KIND_W-1:0];
            s.x = pair_value(asfp_pkg::POS_X);
            s.y = pair_value(asfp_pkg::POS_Y);
            s.z = pair_value(asfp_pkg::POS_Z);
            if (frame_bytes[asfp_pkg::POS_KIND] == asfp_pkg::KIND_POSITION) begin
                s.x = s.x - {origin_x[15], origin_x};
                s.y = s.y - {origin_y[15], origin_y};
                s.z = s.z - {origin_z[15], origin_z};
            end
            pending_status = {pending_status, s};
        endfunction

        function void compare_status(logic [asfp_pkg::KIND_W-1:0] kind,
                                     logic signed [asfp_pkg::VALUE_W-1:0] x,
                                     logic signed [asfp_pkg::VALUE_W-1:0] y,
                                     logic signed [asfp_pkg::VALUE_W-1:0] z);
            t_frame_status e;
            if (pending_status.size() == 0) begin
                $error("unexpected status word: kind %0d x %0d y %0d z %0d",
                       kind, x, y, z);
                errors++;
                return;
            end
            e = pending_status.pop_front();
            if (kind !== e.kind) begin
                $error("frame_kind: expected %0d, actual %0d", e.kind, kind);
                errors++;
            end
            if (x !== e.x) begin
                $error("value_x: expected %0d, actual %0d", e.x, x);
                errors++;
            end
            if (y !== e.y) begin
                $error("value_y: expected %0d, actual %0d", e.y, y);
                errors++;
            end
            if (z !== e.z) begin
                $error("value_z: expected %0d, actual %0d", e.z, z);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return pending_status.size();
        endfunction
    endclass

    localparam int HOLD_CYCLES  = 60;
    localparam int SETTLE_TICKS = 8;

    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_cfg_we    = 1'b0;
    logic [asfp_pkg::CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [asfp_pkg::CFG_DATA_W-1:0]      i_cfg_data  = '0;
    logic                                 i_in_valid  = 1'b0;
    logic [7:0]                           i_rx_byte   = '0;
    logic                                 i_out_stall = 1'b0;
    logic                                 o_in_stall;
    logic                                 o_out_valid;
    logic [asfp_pkg::KIND_W-1:0]          o_frame_kind;
    logic signed [asfp_pkg::VALUE_W-1:0]  o_value_x;
    logic signed [asfp_pkg::VALUE_W-1:0]  o_value_y;
    logic signed [asfp_pkg::VALUE_W-1:0]  o_value_z;

    t_status_board     sb;
    int unsigned       in_idle_pct  = 0;
    int unsigned       out_idle_pct = 0;
    logic              hold_go      = 1'b0;
    int unsigned       hold_left    = 0;

    arm_status_frame_parser_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_frame_kind (o_frame_kind),
        .o_value_x    (o_value_x),
        .o_value_y    (o_value_y),
        .o_value_z    (o_value_z)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result side stall: random, or held high for a long stretch on request.
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    // Both handshakes are observed on the values that held before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.take_rx_byte(i_rx_byte);
            if (o_out_valid && !i_out_stall)
                sb.compare_status(o_frame_kind, o_value_x, o_value_y, o_value_z);
        end
    end

    // Offers one byte, with a random gap before it, and waits for acceptance.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // Sends a whole frame laid out for the current configuration.
    task automatic send_frame(input logic [7:0] kind, input logic [15:0] x, y, z,
                              input logic [7:0] last);
        logic [15:0] vals [3];
        vals = '{x, y, z};
        send_byte(sb.begin_marker);
        foreach (vals[i]) begin
            send_byte(sb.byte_order ? vals[i][15:8] : vals[i][7:0]);
            send_byte(sb.byte_order ? vals[i][7:0] : vals[i][15:8]);
        end
        send_byte(kind);
        send_byte(last);
    endtask

    function automatic logic [15:0] pick_value();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return 16'h8000;
        if (r == 1)
            return 16'h7FFF;
        return 16'($urandom);
    endfunction

    // The first edge lets the monitor note a word accepted at the current edge.
    task automatic wait_results_done();
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_reg(input asfp_pkg::t_cfg_idx idx,
                             input logic [asfp_pkg::CFG_DATA_W-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        sb.set_reg(idx, d);
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic bo, input logic [7:0] bm, em,
                              input logic [15:0] ox, oy, oz);
        write_reg(asfp_pkg::CFG_BYTE_ORDER, {15'd0, bo});
        write_reg(asfp_pkg::CFG_BEGIN_MARKER, {8'd0, bm});
        write_reg(asfp_pkg::CFG_END_MARKER, {8'd0, em});
        write_reg(asfp_pkg::CFG_ORIGIN_X, ox);
        write_reg(asfp_pkg::CFG_ORIGIN_Y, oy);
        write_reg(asfp_pkg::CFG_ORIGIN_Z, oz);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly well-formed frames, with bad kinds, bad end markers, stray bytes
    // and cut-short frames mixed in.
    task automatic run_traffic(input int n_frames);
        int unsigned r;
        int unsigned n;
        logic [7:0]  bad;
        for (int f = 0; f < n_frames; f++) begin
            r = $urandom_range(99);
            if (r < 70) begin
                send_frame(8'($urandom_range(3)), pick_value(), pick_value(), pick_value(),
                           sb.end_marker);
            end else if (r < 78) begin
                send_frame(8'($urandom_range(255, 4)), pick_value(), pick_value(),
                           pick_value(), sb.end_marker);
            end else if (r < 86) begin
                bad = 8'($urandom_range(255, 1));
                send_frame(8'($urandom_range(3)), pick_value(), pick_value(), pick_value(),
                           sb.end_marker ^ bad);
            end else if (r < 93) begin
                n = $urandom_range(4, 1);
                repeat (n) send_byte(8'($urandom));
            end else begin
                n = $urandom_range(7, 1);
                send_byte(sb.begin_marker);
                repeat (n) send_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < 6; ph++) begin
            // Sender idles lightly first, then the receiver, then neither.
            in_idle_pct  = (ph < 2) ? 6 : ((ph < 4) ? 48 : 0);
            out_idle_pct = (ph < 2) ? 48 : ((ph < 4) ? 6 : 0);
            if (ph > 0) begin
                i_in_valid <= 1'b0;
                wait_results_done();
            end
            case (ph)
                1: set_config(1'b0, 8'hFF, 8'h00, 16'h7FFF, 16'h8000, 16'hFFFF);
                2: set_config(1'b1, 8'h00, 8'hFF, 16'h8000, 16'h7FFF, 16'h0000);
                3, 4, 5: set_config(1'($urandom), 8'($urandom), 8'($urandom),
                                    16'($urandom), 16'($urandom), 16'($urandom));
                default: ;
            endcase

            if (ph == 1) begin
                // Position at the far ends of the origin offset.
                send_frame(asfp_pkg::KIND_POSITION, 16'h8000, 16'h7FFF, 16'h0000,
                           sb.end_marker);
                // Data bytes equal to the begin marker are plain data.
                send_frame(8'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, sb.end_marker);
                // Unknown kind gives nothing.
                send_frame(8'h80, pick_value(), pick_value(), pick_value(), sb.end_marker);
            end

            if (ph == 4) begin
                // Receiver holds off while bytes keep coming, filling the block.
                hold_go <= 1'b1;
                @(posedge i_clk);
                hold_go <= 1'b0;
            end

            run_traffic(11);
            if (ph == 2) begin
                i_in_valid <= 1'b0;
                wait_results_done();
            end
            run_traffic(11);
        end

        i_in_valid <= 1'b0;
        wait_results_done();
        if (sb.pending() != 0)
            $error("%0d expected status words never arrived", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/asfp_pkg.sv
sv/asfp_cell.sv
sv/asfp_result.sv
sv/arm_status_frame_parser_unit.sv
verif/arm_status_frame_parser_unit_tb.sv
